// File: sv/csas_pkg.sv
`timescale 1ns / 1ps
// Types and constants shared by the chunked sorted array search unit.
package csas_pkg;

  localparam int DEPTH = 1024;
  localparam int MAX_CHUNKS = 16;
  localparam int IDX_W = 10;
  localparam int VAL_W = 32;
  localparam int CNT_W = 11;
  localparam int WCNT_W = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int QDEPTH = 2;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WORKER_COUNT = 2'd1;

  typedef struct packed {
    logic operation;
    logic [IDX_W-1:0] element_index;
    logic signed [VAL_W-1:0] element_value;
    logic signed [VAL_W-1:0] target_value;
  } in_item_t;

  typedef struct packed {
    logic found;
    logic [IDX_W-1:0] found_index;
  } out_item_t;

  typedef struct packed {
    logic op;
    logic [IDX_W-1:0] element_index;
    logic signed [VAL_W-1:0] value;
    logic [CNT_W-1:0] size;
    logic [WCNT_W-1:0] extra;
    logic [WCNT_W-1:0] wcnt;
  } work_t;

endpackage

// File: sv/csas_front.sv
`timescale 1ns / 1ps
// Front end: accepts items, clamps the configuration and divides the range into chunks.
module csas_front (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  csas_pkg::in_item_t item,
  input  logic [csas_pkg::CNT_W-1:0] element_count,
  input  logic [csas_pkg::WCNT_W-1:0] worker_count,
  input  logic q_full,
  output logic push,
  output csas_pkg::work_t push_data
);
  import csas_pkg::*;

  localparam logic F_IDLE = 1'b0;
  localparam logic F_DIV = 1'b1;
  localparam int STEP_W = $clog2(CNT_W);

  logic state;
  logic [STEP_W-1:0] step;
  logic [CNT_W-1:0] quot;
  logic [WCNT_W-1:0] rem;
  logic [WCNT_W-1:0] wreg;
  logic signed [VAL_W-1:0] target;

  logic accept;
  logic last_step;
  logic [CNT_W-1:0] n_sat;
  logic [WCNT_W-1:0] w_sat;
  logic [WCNT_W:0] trial;
  logic [WCNT_W:0] diff;
  logic ge;
  logic [WCNT_W-1:0] rem_next;
  logic [CNT_W-1:0] quot_next;

  assign busy = (state == F_DIV) || q_full;
  assign accept = start && !busy;
  assign last_step = (state == F_DIV) && (step == STEP_W'(CNT_W - 1));

  assign n_sat = (32'(element_count) > DEPTH) ? CNT_W'(DEPTH) : element_count;

  always_comb begin
    if (worker_count == '0) begin
      w_sat = WCNT_W'(1);
    end else if (32'(worker_count) > MAX_CHUNKS) begin
      w_sat = WCNT_W'(MAX_CHUNKS);
    end else begin
      w_sat = worker_count;
    end
  end

  // restoring divide, one quotient bit per cycle
  assign trial = {rem, quot[CNT_W-1]};
  assign ge = trial >= {1'b0, wreg};
  assign diff = trial - {1'b0, wreg};
  assign rem_next = ge ? diff[WCNT_W-1:0] : trial[WCNT_W-1:0];
  assign quot_next = {quot[CNT_W-2:0], ge};

  assign push = (accept && item.operation == OP_STORE) || last_step;

  always_comb begin
    push_data.op = OP_STORE;
    push_data.element_index = item.element_index;
    push_data.value = item.element_value;
    push_data.size = '0;
    push_data.extra = '0;
    push_data.wcnt = '0;
    if (state == F_DIV) begin
      push_data.op = OP_SEARCH;
      push_data.element_index = '0;
      push_data.value = target;
      push_data.size = quot_next;
      push_data.extra = rem_next;
      push_data.wcnt = wreg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      step <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept && item.operation == OP_SEARCH) begin
            state <= F_DIV;
            step <= '0;
            quot <= n_sat;
            rem <= '0;
            wreg <= w_sat;
            target <= item.target_value;
          end
        end
        F_DIV: begin
          quot <= quot_next;
          rem <= rem_next;
          step <= step + 1'b1;
          if (last_step) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sv/csas_queue.sv
`timescale 1ns / 1ps
// Two-entry work queue between the front end and the search engine.
module csas_queue (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  csas_pkg::work_t push_data,
  output logic full,
  output logic q_valid,
  output csas_pkg::work_t q_data,
  input  logic pop
);
  import csas_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);

  work_t entries [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0] count;

  logic do_push;
  logic do_pop;

  assign full = (count == (PTR_W+1)'(QDEPTH));
  assign q_valid = (count != '0);
  assign q_data = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: sv/csas_back.sv
`timescale 1ns / 1ps
// Search engine: element store, chunk sequencer and binary search over each chunk.
module csas_back #(
  parameter int DATA_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  csas_pkg::work_t q_data,
  output logic pop,
  output logic done,
  output csas_pkg::out_item_t result
);
  import csas_pkg::*;

  localparam int AW = $clog2(DEPTH);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_CHUNK = 2'd1;
  localparam logic [1:0] B_READ = 2'd2;
  localparam logic [1:0] B_CMP = 2'd3;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata;

  logic [1:0] state;
  work_t cur;
  logic signed [DATA_WIDTH-1:0] key;
  logic [WCNT_W-1:0] t;
  logic [CNT_W-1:0] cstart;
  logic [CNT_W-1:0] cend;
  logic [CNT_W-1:0] lo;
  logic [CNT_W-1:0] hi_ex;
  logic [CNT_W-1:0] mid;

  logic [CNT_W-1:0] len;
  logic [CNT_W-1:0] span;
  logic [CNT_W-1:0] mid_c;
  logic probe;
  logic store_wr;
  logic signed [DATA_WIDTH-1:0] elem;

  assign pop = (state == B_IDLE) && q_valid;
  assign store_wr = pop && (q_data.op == OP_STORE) && (32'(q_data.element_index) < DEPTH);

  assign len = cur.size + CNT_W'(t < cur.extra);
  assign span = hi_ex - lo - 1'b1;
  assign mid_c = lo + (span >> 1);
  assign probe = (state == B_READ) && (lo < hi_ex);
  assign elem = $signed(rdata);

  always_ff @(posedge clk) begin
    if (store_wr) begin
      mem[AW'(q_data.element_index)] <= DATA_WIDTH'(q_data.value);
    end
    if (probe) begin
      rdata <= mem[AW'(mid_c)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        B_IDLE: begin
          if (pop && q_data.op == OP_SEARCH) begin
            cur <= q_data;
            key <= DATA_WIDTH'(q_data.value);
            t <= '0;
            cstart <= '0;
            state <= B_CHUNK;
          end
        end
        B_CHUNK: begin
          // chunk lengths never grow, so an empty chunk ends the search
          if (len == '0) begin
            done <= 1'b1;
            result <= '0;
            state <= B_IDLE;
          end else begin
            lo <= cstart;
            hi_ex <= cstart + len;
            cend <= cstart + len;
            state <= B_READ;
          end
        end
        B_READ: begin
          if (probe) begin
            mid <= mid_c;
            state <= B_CMP;
          end else if (WCNT_W'(t + 1'b1) == cur.wcnt) begin
            done <= 1'b1;
            result <= '0;
            state <= B_IDLE;
          end else begin
            t <= t + 1'b1;
            cstart <= cend;
            state <= B_CHUNK;
          end
        end
        B_CMP: begin
          if (elem > key) begin
            hi_ex <= mid;
            state <= B_READ;
          end else if (elem < key) begin
            lo <= mid + 1'b1;
            state <= B_READ;
          end else begin
            done <= 1'b1;
            result.found <= 1'b1;
            result.found_index <= mid[IDX_W-1:0];
            state <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sv/chunked_sorted_array_search_unit.sv
`timescale 1ns / 1ps
// Top level of the chunked sorted array search unit: configuration registers and wiring.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+----------------------------
//   input    | start, busy             | item (in_item_t)
//   result   | done (one-cycle strobe) | result (out_item_t)
//   config   | cfg_valid, cfg_ready    | cfg_index, cfg_data
//
// A store is written into the element store when the search engine pops it. A search
// first runs the front-end divider, then per chunk a setup state, a registered read and
// a compare per memory probe, and a last read state once the chunk's range is empty.
// The two-entry queue lets the front end take a store or start a divide while
// the engine is searching; busy rises while dividing or when the queue is full.
// rst is synchronous and clears control state only; the store is undefined until written.
module chunked_sorted_array_search_unit #(
  parameter int DATA_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  csas_pkg::in_item_t item,
  output logic done,
  output csas_pkg::out_item_t result,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [csas_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [csas_pkg::CFG_DATA_W-1:0] cfg_data
);
  import csas_pkg::*;

  logic [CNT_W-1:0] element_count;
  logic [WCNT_W-1:0] worker_count;

  logic push;
  work_t push_data;
  logic q_full;
  logic q_valid;
  work_t q_data;
  logic pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= '0;
      worker_count <= WCNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ELEMENT_COUNT: element_count <= cfg_data[CNT_W-1:0];
        REG_WORKER_COUNT: worker_count <= cfg_data[WCNT_W-1:0];
        default: ;
      endcase
    end
  end

  csas_front u_front (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .element_count(element_count),
    .worker_count(worker_count),
    .q_full(q_full),
    .push(push),
    .push_data(push_data)
  );

  csas_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_data(push_data),
    .full(q_full),
    .q_valid(q_valid),
    .q_data(q_data),
    .pop(pop)
  );

  csas_back #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .q_data(q_data),
    .pop(pop),
    .done(done),
    .result(result)
  );

`ifndef NO_ASSERTIONS
  a_miss_index_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.found |-> result.found_index == '0)
    else $error("miss reported with nonzero index");

  a_no_back_to_back_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two results in consecutive cycles");

  a_no_done_after_reset: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");

  a_push_never_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("front end pushed into a full queue");
`endif

endmodule
